[src/bir_pkg.sv]
// ----------------------------------------------------------------------------
// bir_pkg
// Shared constants, register codes and sequencer states of the bilinear
// image resize engine.
// ----------------------------------------------------------------------------
package bir_pkg;

   // frame geometry and fraction precision
   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int FRAC_BITS   = 8;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // field widths
   localparam int CH_W        = 8;
   localparam int PIX_W       = 3 * CH_W;
   localparam int LOAD_W      = 9;
   localparam int OCOORD_W    = 12;
   localparam int DIM_W       = 10;
   localparam int SCALE_W     = 25;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 25;

   // Q21.16 position arithmetic
   localparam int POINT       = 16;
   localparam int POS_W       = OCOORD_W + SCALE_W;
   localparam int INT_W       = POS_W - POINT;
   localparam int ONE         = 1 << FRAC_BITS;
   localparam int OMF_W       = FRAC_BITS + 1;
   localparam int WGT_W       = 2 * FRAC_BITS + 1;
   localparam int ACC_W       = 2 * FRAC_BITS + CH_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_WIDTH,
      REG_SRC_HEIGHT,
      REG_SCALE_X,
      REG_SCALE_Y
   } bir_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOC,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_FIN,
      ST_OUT
   } bir_state_type;

endpackage

[src/bir_if.sv]
// ----------------------------------------------------------------------------
// bir_if
// Valid/ready channels of the bilinear image resize engine: request,
// response and register write.
// ----------------------------------------------------------------------------
interface bir_req_if import bir_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                cmd;
   logic [LOAD_W-1:0]   load_col;
   logic [LOAD_W-1:0]   load_row;
   logic [CH_W-1:0]     in_blue;
   logic [CH_W-1:0]     in_green;
   logic [CH_W-1:0]     in_red;
   logic [OCOORD_W-1:0] out_col;
   logic [OCOORD_W-1:0] out_row;

   modport source (
      output valid, cmd, load_col, load_row, in_blue, in_green, in_red,
             out_col, out_row,
      input  ready
   );
   modport sink (
      input  valid, cmd, load_col, load_row, in_blue, in_green, in_red,
             out_col, out_row,
      output ready
   );
endinterface

interface bir_rsp_if import bir_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] out_blue;
   logic [CH_W-1:0] out_green;
   logic [CH_W-1:0] out_red;

   modport source (output valid, out_blue, out_green, out_red, input ready);
   modport sink   (input valid, out_blue, out_green, out_red, output ready);
endinterface

interface bir_csr_if import bir_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/bilinear_image_resize.sv]
// ----------------------------------------------------------------------------
// bilinear_image_resize
// Frame store plus a bilinear sampler that answers one output pixel per
// query from four neighbouring source pixels.
// ----------------------------------------------------------------------------
// A load transfer (cmd 0) writes one BGR pixel into the frame memory; the
// block stays ready, so loads can be taken one per cycle while it is idle.
// A query transfer (cmd 1) reaches the result register in these steps: the
// position multiply happens at the transfer, the locate state clamps the
// position and forms the four weights, then the four neighbours are read
// one per cycle from the frame memory (one registered read port), a
// multiply-accumulate folds each returned pixel in the state after its read,
// and the output state moves the rounded sum into the result register. The
// block takes its next item once the query leaves the output state, so it
// takes no new item while a query is in flight; the four reads are serial
// through the single read port. If the result register still holds an
// unaccepted result, the query waits in the output state until the response
// side takes it. The result register decouples the response side, so a new
// item can be taken while a finished result still waits. Pixels must be
// loaded before a query reads them; the memory has no reset and no clearing pass.
// ----------------------------------------------------------------------------
module bilinear_image_resize import bir_pkg::*; (
   input logic        clock,
   input logic        reset,
   bir_req_if.sink    req_ch,
   bir_rsp_if.source  rsp_ch,
   bir_csr_if.sink    csr_ch
);

   // configuration registers
   logic [DIM_W-1:0]   src_width_ff, src_height_ff;
   logic [SCALE_W-1:0] scale_x_ff, scale_y_ff;

   // sequencer
   bir_state_type state_ff, state_in;

   // position and neighbour registers
   logic [POS_W-1:0]   sx_ff, sy_ff;
   logic [COL_W-1:0]   x0_ff, x1_ff, x0_in, x1_in, last_x;
   logic [ROW_W-1:0]   y0_ff, y1_ff, y0_in, y1_in, last_y;
   logic [WGT_W-1:0]   w00_ff, w01_ff, w10_ff, w11_ff;
   logic [WGT_W-1:0]   w00_in, w01_in, w10_in, w11_in;
   logic [INT_W-1:0]   ip_x, ip_y;
   logic [FRAC_BITS-1:0] fx, fy;
   logic [OMF_W-1:0]   omfx, omfy;

   // frame memory
   logic [PIX_W-1:0]   frame_mem [STORE_DEPTH];
   logic [PIX_W-1:0]   rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [COL_W-1:0]   rd_col;
   logic [ROW_W-1:0]   rd_row;
   logic               mem_we;

   // accumulators, one per channel
   logic [ACC_W-1:0]   acc_ff [3];
   logic [ACC_W-1:0]   acc_in [3];
   logic [WGT_W-1:0]   wsel;
   logic               mac_en;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]    rsp_pix_ff [3];
   logic               rsp_load;

   logic               req_xfer, query_xfer;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign query_xfer   = req_xfer && req_ch.cmd;

   // ---------------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= DIM_W'(512);
         src_height_ff <= DIM_W'(512);
         scale_x_ff    <= SCALE_W'(65536);
         scale_y_ff    <= SCALE_W'(65536);
      end else if (csr_ch.valid && csr_ch.ready) begin
         case (bir_reg_type'(csr_ch.index))
            REG_SRC_WIDTH:  src_width_ff  <= csr_ch.data[DIM_W-1:0];
            REG_SRC_HEIGHT: src_height_ff <= csr_ch.data[DIM_W-1:0];
            REG_SCALE_X:    scale_x_ff    <= csr_ch.data[SCALE_W-1:0];
            REG_SCALE_Y:    scale_y_ff    <= csr_ch.data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // last usable column and row, with the dimensions saturated to 1..max
   always_comb begin
      if (src_width_ff == '0)
         last_x = '0;
      else if (32'(src_width_ff) > MAX_WIDTH)
         last_x = COL_W'(MAX_WIDTH - 1);
      else
         last_x = COL_W'(src_width_ff - DIM_W'(1));

      if (src_height_ff == '0)
         last_y = '0;
      else if (32'(src_height_ff) > MAX_HEIGHT)
         last_y = ROW_W'(MAX_HEIGHT - 1);
      else
         last_y = ROW_W'(src_height_ff - DIM_W'(1));
   end

   // ---------------------------------------------------------------------
   // neighbour location and weights (formed in the locate cycle)
   // ---------------------------------------------------------------------
   always_comb begin
      ip_x = sx_ff[POS_W-1:POINT];
      ip_y = sy_ff[POS_W-1:POINT];

      // clamp integer part to the frame edge
      x0_in = (ip_x > INT_W'(last_x)) ? last_x : ip_x[COL_W-1:0];
      y0_in = (ip_y > INT_W'(last_y)) ? last_y : ip_y[ROW_W-1:0];
      x1_in = (x0_in == last_x) ? x0_in : x0_in + COL_W'(1);
      y1_in = (y0_in == last_y) ? y0_in : y0_in + ROW_W'(1);

      // fraction bits just below the binary point
      fx   = sx_ff[POINT-1 -: FRAC_BITS];
      fy   = sy_ff[POINT-1 -: FRAC_BITS];
      omfx = OMF_W'(ONE) - OMF_W'(fx);
      omfy = OMF_W'(ONE) - OMF_W'(fy);

      w00_in = WGT_W'(omfx) * WGT_W'(omfy);
      w01_in = WGT_W'(fx)   * WGT_W'(omfy);
      w10_in = WGT_W'(omfx) * WGT_W'(fy);
      w11_in = WGT_W'(fx)   * WGT_W'(fy);
   end

   always_ff @(posedge clock) begin
      if (query_xfer) begin
         sx_ff <= POS_W'(req_ch.out_col) * POS_W'(scale_x_ff);
         sy_ff <= POS_W'(req_ch.out_row) * POS_W'(scale_y_ff);
      end
      if (state_ff == ST_LOC) begin
         x0_ff  <= x0_in;
         x1_ff  <= x1_in;
         y0_ff  <= y0_in;
         y1_ff  <= y1_in;
         w00_ff <= w00_in;
         w01_ff <= w01_in;
         w10_ff <= w10_in;
         w11_ff <= w11_in;
      end
   end

   // ---------------------------------------------------------------------
   // frame memory: one write port for loads, one registered read port
   // ---------------------------------------------------------------------
   assign wr_addr = ADDR_W'(req_ch.load_row) * ADDR_W'(MAX_WIDTH)
                  + ADDR_W'(req_ch.load_col);
   // loads outside the store are dropped
   assign mem_we  = req_xfer && !req_ch.cmd
                  && (32'(req_ch.load_col) < MAX_WIDTH)
                  && (32'(req_ch.load_row) < MAX_HEIGHT);

   // neighbour order: upper-left, upper-right, lower-left, lower-right
   always_comb begin
      case (state_ff)
         ST_RD0:  begin rd_row = y0_ff; rd_col = x0_ff; end
         ST_RD1:  begin rd_row = y0_ff; rd_col = x1_ff; end
         ST_RD2:  begin rd_row = y1_ff; rd_col = x0_ff; end
         ST_RD3:  begin rd_row = y1_ff; rd_col = x1_ff; end
         default: begin rd_row = y0_ff; rd_col = x0_ff; end
      endcase
   end

   assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_col);

   always_ff @(posedge clock) begin
      if (mem_we)
         frame_mem[wr_addr] <= {req_ch.in_red, req_ch.in_green, req_ch.in_blue};
      rd_data_ff <= frame_mem[rd_addr];
   end

   // ---------------------------------------------------------------------
   // multiply-accumulate, one neighbour per cycle, read data registered behind its address
   // ---------------------------------------------------------------------
   always_comb begin
      mac_en = 1'b1;
      case (state_ff)
         ST_RD1:  wsel = w00_ff;
         ST_RD2:  wsel = w01_ff;
         ST_RD3:  wsel = w10_ff;
         ST_FIN:  wsel = w11_ff;
         default: begin wsel = '0; mac_en = 1'b0; end
      endcase

      for (int k = 0; k < 3; k++) begin
         if (state_ff == ST_LOC)
            // preload the half-unit so the final shift rounds to nearest
            acc_in[k] = ACC_W'(1) << (2 * FRAC_BITS - 1);
         else if (mac_en)
            acc_in[k] = acc_ff[k]
                      + ACC_W'(wsel) * ACC_W'(rd_data_ff[k*CH_W +: CH_W]);
         else
            acc_in[k] = acc_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++)
         acc_ff[k] <= acc_in[k];
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: if (query_xfer) state_in = ST_LOC;
         ST_LOC:  state_in = ST_RD0;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_RD3;
         ST_RD3:  state_in = ST_FIN;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_comb begin
      if (rsp_load)
         rsp_valid_in = 1'b1;
      else if (rsp_ch.ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         for (int k = 0; k < 3; k++)
            rsp_pix_ff[k] <= acc_ff[k][ACC_W-1 -: CH_W];
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.out_blue  = rsp_pix_ff[0];
   assign rsp_ch.out_green = rsp_pix_ff[1];
   assign rsp_ch.out_red   = rsp_pix_ff[2];

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // a query transfer always starts the locate cycle
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      query_xfer |=> state_ff == ST_LOC)
      else $error("query transfer did not start the sampler");

   // the four weights always cover exactly one unit squared
   a_weight_sum: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD0 |->
         (32'(w00_ff) + 32'(w01_ff) + 32'(w10_ff) + 32'(w11_ff)) == ONE * ONE)
      else $error("bilinear weights do not sum to one");

   // the right and lower neighbours are the same or one step further
   a_neighbours: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RD0 |->
         (x1_ff == x0_ff || x1_ff == x0_ff + COL_W'(1)) &&
         (y1_ff == y0_ff || y1_ff == y0_ff + ROW_W'(1)))
      else $error("neighbour coordinates out of step");

   // a new result only appears out of the output state
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside the output state");

endmodule
